/* hdl/bb_pkg.sv */
`timescale 1ns / 1ps

package bb_pkg;

  localparam int MAX_WIDTH  = 2048;
  localparam int MAX_HEIGHT = 4096;

  localparam int PIX_W = 24;
  localparam int COL_W = 11;
  localparam int ROW_W = 12;
  localparam int FW_W  = 12;
  localparam int FH_W  = 13;
  localparam int CFG_W = 13;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;

  typedef logic [PIX_W-1:0] pixel_t;

  // Window row m holds rows r-2+m, column k holds columns c-2+k.
  typedef pixel_t [2:0][2:0] window_t;

  typedef enum logic {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic r_ge1;
    logic r_ge2;
    logic r_last;
    logic c_ge1;
    logic c_ge2;
    logic c_last;
  } edge_flags_t;

  typedef struct packed {
    window_t             win;
    logic [ROW_W-1:0]    row;
    logic [COL_W-1:0]    col;
    edge_flags_t         flags;
  } job_t;

endpackage

/* hdl/bb_pixel_if.sv */
`timescale 1ns / 1ps

interface bb_pixel_if;
  logic        valid;
  logic        ready;
  logic [23:0] pixel;

  modport source (output valid, output pixel, input ready);
  modport sink   (input valid, input pixel, output ready);
endinterface

/* hdl/bb_result_if.sv */
`timescale 1ns / 1ps

interface bb_result_if;
  logic        valid;
  logic        ready;
  logic [23:0] blurred;
  logic [11:0] out_row;
  logic [10:0] out_col;
  logic        run_last;

  modport source (output valid, output blurred, output out_row, output out_col,
                  output run_last, input ready);
  modport sink   (input valid, input blurred, input out_row, input out_col,
                  input run_last, output ready);
endinterface

/* hdl/bb_front.sv */
`timescale 1ns / 1ps

module bb_front
  import bb_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic [FW_W-1:0]  width,
  input  logic [FH_W-1:0]  height,
  bb_pixel_if.sink         pixels,
  output job_t             job,
  output logic             job_valid,
  input  logic             job_ready
);

  typedef enum logic [1:0] {F_IDLE, F_LOAD, F_PUSH} fstate_t;

  fstate_t          state;
  logic [COL_W-1:0] col_count;
  logic [ROW_W-1:0] row_count;
  logic [COL_W-1:0] cur_c;
  logic [ROW_W-1:0] cur_r;
  pixel_t           cur_pix;
  window_t          win;
  logic [2*PIX_W-1:0] line_mem [MAX_WIDTH];
  logic [2*PIX_W-1:0] rd_data;

  logic [COL_W-1:0] c_start;
  logic [FH_W-1:0]  r_wrap;
  logic [ROW_W-1:0] r_start;
  logic [FW_W-1:0]  c_inc;
  logic [FH_W-1:0]  r_inc;
  logic [COL_W-1:0] col_count_next;
  logic [ROW_W-1:0] row_count_next;
  pixel_t           above1;
  pixel_t           above2;
  window_t          win_next;
  logic [2*PIX_W-1:0] wr_data;
  edge_flags_t      flags;
  logic             has_result;
  logic             accept;

  assign pixels.ready = (state == F_IDLE);
  assign accept       = pixels.valid && pixels.ready;
  assign job_valid    = (state == F_PUSH);

  // Position of the incoming pixel, wrapped against the current frame size.
  always_comb begin
    if ({1'b0, col_count} >= width) begin
      c_start = '0;
      r_wrap  = {1'b0, row_count} + FH_W'(1);
    end else begin
      c_start = col_count;
      r_wrap  = {1'b0, row_count};
    end
    r_start = (r_wrap >= height) ? '0 : r_wrap[ROW_W-1:0];
  end

  // Position of the next pixel.
  always_comb begin
    c_inc = {1'b0, cur_c} + FW_W'(1);
    r_inc = {1'b0, cur_r} + FH_W'(1);
    if (c_inc >= width) begin
      col_count_next = '0;
      row_count_next = (r_inc >= height) ? '0 : r_inc[ROW_W-1:0];
    end else begin
      col_count_next = c_inc[COL_W-1:0];
      row_count_next = cur_r;
    end
  end

  // Bank r[0] holds the row two above, the other bank the row just above.
  always_comb begin
    above2 = cur_r[0] ? rd_data[2*PIX_W-1:PIX_W] : rd_data[PIX_W-1:0];
    above1 = cur_r[0] ? rd_data[PIX_W-1:0] : rd_data[2*PIX_W-1:PIX_W];
    wr_data = cur_r[0] ? {cur_pix, rd_data[PIX_W-1:0]}
                       : {rd_data[2*PIX_W-1:PIX_W], cur_pix};
    for (int m = 0; m < 3; m++) begin
      win_next[m][0] = win[m][1];
      win_next[m][1] = win[m][2];
    end
    win_next[0][2] = above2;
    win_next[1][2] = above1;
    win_next[2][2] = cur_pix;
  end

  always_comb begin
    flags.r_ge1  = (cur_r != '0);
    flags.r_ge2  = |cur_r[ROW_W-1:1];
    flags.r_last = (({1'b0, cur_r} + FH_W'(1)) == height);
    flags.c_ge1  = (cur_c != '0);
    flags.c_ge2  = |cur_c[COL_W-1:1];
    flags.c_last = (({1'b0, cur_c} + FW_W'(1)) == width);
    has_result   = (flags.r_ge1 || flags.r_last) && (flags.c_ge1 || flags.c_last);
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rd_data <= line_mem[c_start];
    end
    if (state == F_LOAD) begin
      line_mem[cur_c] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= F_IDLE;
      col_count <= '0;
      row_count <= '0;
      win       <= '0;
    end else begin
      case (state)
        F_IDLE: begin
          if (accept) begin
            cur_c   <= c_start;
            cur_r   <= r_start;
            cur_pix <= pixels.pixel;
            state   <= F_LOAD;
          end
        end
        F_LOAD: begin
          win       <= win_next;
          col_count <= col_count_next;
          row_count <= row_count_next;
          job.win   <= win_next;
          job.row   <= cur_r;
          job.col   <= cur_c;
          job.flags <= flags;
          state     <= has_result ? F_PUSH : F_IDLE;
        end
        F_PUSH: begin
          if (job_ready) begin
            state <= F_IDLE;
          end
        end
        default: state <= F_IDLE;
      endcase
    end
  end

endmodule

/* hdl/bb_queue.sv */
`timescale 1ns / 1ps

module bb_queue
  import bb_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  job_t push_job,
  input  logic push,
  output logic not_full,
  output job_t pop_job,
  output logic not_empty,
  input  logic pop
);

  job_t              slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   fill;
  logic              do_push;
  logic              do_pop;

  assign not_full  = (fill != (QPTR_W+1)'(QUEUE_DEPTH));
  assign not_empty = (fill != '0);
  assign do_push   = push && not_full;
  assign do_pop    = pop && not_empty;
  assign pop_job   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + QPTR_W'(1);
      if (do_pop)  rd_ptr <= rd_ptr + QPTR_W'(1);
      if (do_push && !do_pop) fill <= fill + (QPTR_W+1)'(1);
      else if (do_pop && !do_push) fill <= fill - (QPTR_W+1)'(1);
    end
  end

endmodule

/* hdl/bb_back.sv */
`timescale 1ns / 1ps

module bb_back
  import bb_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  job_t      job,
  input  logic      job_valid,
  output logic      job_pop,
  bb_result_if.source results
);

  // floor(x / 3) = (x * 2731) >> 13 for every x below 8192.
  localparam int          SUM_W       = 12;
  localparam logic [11:0] THIRD_MUL   = 12'd2731;
  localparam int          THIRD_SHIFT = 13;

  typedef enum logic [2:0] {B_IDLE, B_SUM, B_DIV1, B_DIV2, B_OUT} bstate_t;

  bstate_t          state;
  job_t             cur;
  logic             ai;
  logic             bi;
  logic [SUM_W-1:0] sum_q [3];
  logic [3:0]       n_q;
  logic [SUM_W-1:0] t_q [3];
  logic [ROW_W-1:0] row_q;
  logic [COL_W-1:0] col_q;
  logic             last_q;

  logic             last_a;
  logic             last_b;
  logic             col_is_cur;
  logic             row_is_cur;
  logic [2:0]       rmask;
  logic [2:0]       cmask;
  logic [1:0]       nr;
  logic [1:0]       nc;
  logic [3:0]       n_calc;
  logic [SUM_W-1:0] sum_calc [3];
  logic [SUM_W-1:0] y [3];
  logic [SUM_W-1:0] pre [3];
  logic [SUM_W-1:0] mul_in [3];
  logic [2*SUM_W-1:0] prod [3];
  logic [SUM_W-1:0] third [3];
  logic             by_three;

  assign job_pop = (state == B_IDLE) && job_valid;

  assign results.valid    = (state == B_OUT);
  assign results.blurred  = {t_q[2][7:0], t_q[1][7:0], t_q[0][7:0]};
  assign results.out_row  = row_q;
  assign results.out_col  = col_q;
  assign results.run_last = last_q;

  // Column outer, row inner; the first choice is the previous row or column.
  always_comb begin
    last_a     = cur.flags.c_ge1 && cur.flags.c_last;
    last_b     = cur.flags.r_ge1 && cur.flags.r_last;
    col_is_cur = !cur.flags.c_ge1 || ai;
    row_is_cur = !cur.flags.r_ge1 || bi;
    rmask[2]   = 1'b1;
    rmask[1]   = row_is_cur ? cur.flags.r_ge1 : 1'b1;
    rmask[0]   = row_is_cur ? 1'b0 : cur.flags.r_ge2;
    cmask[2]   = 1'b1;
    cmask[1]   = col_is_cur ? cur.flags.c_ge1 : 1'b1;
    cmask[0]   = col_is_cur ? 1'b0 : cur.flags.c_ge2;
    nr         = 2'(rmask[0]) + 2'(rmask[1]) + 2'(rmask[2]);
    nc         = 2'(cmask[0]) + 2'(cmask[1]) + 2'(cmask[2]);
    n_calc     = {2'b00, nr} * {2'b00, nc};
  end

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      sum_calc[ch] = '0;
      for (int m = 0; m < 3; m++) begin
        for (int k = 0; k < 3; k++) begin
          if (rmask[m] && cmask[k]) begin
            sum_calc[ch] = sum_calc[ch] + SUM_W'(cur.win[m][k][ch*8 +: 8]);
          end
        end
      end
    end
  end

  // Round half up: floor((2s + n) / 2n) = floor((s + floor(n/2)) / n).
  always_comb begin
    by_three = (n_q == 4'd3) || (n_q == 4'd6) || (n_q == 4'd9);
    for (int ch = 0; ch < 3; ch++) begin
      y[ch] = sum_q[ch] + SUM_W'(n_q[3:1]);
      case (n_q)
        4'd2, 4'd6: pre[ch] = y[ch] >> 1;
        4'd4:       pre[ch] = y[ch] >> 2;
        default:    pre[ch] = y[ch];
      endcase
      mul_in[ch] = (state == B_DIV1) ? pre[ch] : t_q[ch];
      prod[ch]   = mul_in[ch] * THIRD_MUL;
      third[ch]  = SUM_W'(prod[ch][2*SUM_W-1:THIRD_SHIFT]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
    end else begin
      case (state)
        B_IDLE: begin
          if (job_valid) begin
            cur   <= job;
            ai    <= 1'b0;
            bi    <= 1'b0;
            state <= B_SUM;
          end
        end
        B_SUM: begin
          for (int ch = 0; ch < 3; ch++) sum_q[ch] <= sum_calc[ch];
          n_q    <= n_calc;
          row_q  <= row_is_cur ? cur.row : cur.row - ROW_W'(1);
          col_q  <= col_is_cur ? cur.col : cur.col - COL_W'(1);
          last_q <= (ai == last_a) && (bi == last_b);
          state  <= B_DIV1;
        end
        B_DIV1: begin
          for (int ch = 0; ch < 3; ch++) t_q[ch] <= by_three ? third[ch] : pre[ch];
          state <= B_DIV2;
        end
        B_DIV2: begin
          if (n_q == 4'd9) begin
            for (int ch = 0; ch < 3; ch++) t_q[ch] <= third[ch];
          end
          state <= B_OUT;
        end
        B_OUT: begin
          if (results.ready) begin
            if (bi != last_b) begin
              bi    <= 1'b1;
              state <= B_SUM;
            end else if (ai != last_a) begin
              bi    <= 1'b0;
              ai    <= 1'b1;
              state <= B_SUM;
            end else begin
              state <= B_IDLE;
            end
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

endmodule

/* hdl/box_blur_3x3_edge_aware.sv */
`timescale 1ns / 1ps

// 3x3 edge-aware box blur for 24-bit RGB pixels (red 23:16, green 15:8,
// blue 7:0) in raster order.
// Pixels enter on the pixels channel; each beat is taken when valid and ready
// are both high. Blurred pixels leave on the results channel, each beat with
// its row, its column and run_last, which marks the final result of the
// input pixel that caused it. One input pixel gives zero to four results.
// The frame size is set through cfg_we, cfg_index and cfg_data and resets to
// 640 by 480. The user must write it only while the block is idle; the block
// itself does not enforce this.
// For each pixel that releases results the front end accepts it and reads the
// line store, shifts the window and writes the line store back, then hands the
// window to the queue, waiting while the queue is full; a pixel with no result
// skips the hand-over. It takes no new pixel until the last one is done.
// The back end takes a window from the queue, then for each result sums,
// runs two divide steps and outputs, waiting while the receiver stalls; it
// takes no new window until the last result of the current one has left.
// A four-deep queue of windows sits between the two, so the front keeps
// taking pixels until the queue is full while a result is held by a stalled
// receiver.
// Reset, synchronous and active high, clears the position counters, the
// window, the queue and both state machines; the line store is not cleared,
// since entries not yet written in a frame are masked out by the edge flags.
module box_blur_3x3_edge_aware
  import bb_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  bb_pixel_if.sink         pixels,
  bb_result_if.source      results
);

  logic [FW_W-1:0] frame_width;
  logic [FH_W-1:0] frame_height;
  logic [FW_W-1:0] eff_width;
  logic [FH_W-1:0] eff_height;

  job_t front_job;
  logic front_valid;
  logic queue_not_full;
  job_t back_job;
  logic queue_not_empty;
  logic back_pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= FW_W'(640);
      frame_height <= FH_W'(480);
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_FRAME_WIDTH:  frame_width  <= cfg_data[FW_W-1:0];
        REG_FRAME_HEIGHT: frame_height <= cfg_data[FH_W-1:0];
        default: ;
      endcase
    end
  end

  // A zero size acts as one; an oversize width is clipped to the line store, an oversize height to MAX_HEIGHT.
  always_comb begin
    if (frame_width == '0) eff_width = FW_W'(1);
    else if (frame_width > FW_W'(MAX_WIDTH)) eff_width = FW_W'(MAX_WIDTH);
    else eff_width = frame_width;
    if (frame_height == '0) eff_height = FH_W'(1);
    else if (frame_height > FH_W'(MAX_HEIGHT)) eff_height = FH_W'(MAX_HEIGHT);
    else eff_height = frame_height;
  end

  bb_front u_front (
    .clk       (clk),
    .rst       (rst),
    .width     (eff_width),
    .height    (eff_height),
    .pixels    (pixels),
    .job       (front_job),
    .job_valid (front_valid),
    .job_ready (queue_not_full)
  );

  bb_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push_job  (front_job),
    .push      (front_valid),
    .not_full  (queue_not_full),
    .pop_job   (back_job),
    .not_empty (queue_not_empty),
    .pop       (back_pop)
  );

  bb_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job       (back_job),
    .job_valid (queue_not_empty),
    .job_pop   (back_pop),
    .results   (results)
  );

endmodule

/* hdl/bb_checker.sv */
`timescale 1ns / 1ps

module bb_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [23:0] blurred,
  input logic [11:0] out_row,
  input logic [10:0] out_col,
  input logic        run_last
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(blurred) && $stable(out_row)
      && $stable(out_col) && $stable(run_last))
    else $error("stalled result beat changed");

  a_reset_quiet: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result beat right after reset");

  a_reset_ready: assert property (@(posedge clk) rst |=> in_ready)
    else $error("input not ready after reset");

endmodule

bind box_blur_3x3_edge_aware bb_checker u_bb_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (pixels.ready),
  .out_valid (results.valid),
  .out_ready (results.ready),
  .blurred   (results.blurred),
  .out_row   (results.out_row),
  .out_col   (results.out_col),
  .run_last  (results.run_last)
);
